FILE: rtl/vector_refraction_macros.svh
// ----------------------------------------------------------------------------
// vector_refraction assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFRACTION_MACROS_SVH
`define VECTOR_REFRACTION_MACROS_SVH

// same-cycle implication, disabled in reset
`define VR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define VR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/vr_pkg.sv
// ----------------------------------------------------------------------------
// vr_pkg
// Types, fixed-point constants and saturation helpers for vector_refraction.
// ----------------------------------------------------------------------------
`default_nettype none
package vr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QW        = 32;
   // radicand k << FRAC_BITS, k nonnegative so 31 significant bits
   localparam int XW        = QW - 1 + FRAC_BITS;
   localparam int RW        = (XW + 1) / 2;
   localparam int XP        = 2 * RW;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [63:0]   prod_type;
   typedef logic signed [65:0]   wide_type;

   localparam q_type    ONE_Q = QW'(64'd1 << FRAC_BITS);
   localparam wide_type W_MAX = 66'sh0_7FFF_FFFF;
   localparam wide_type W_MIN = -(66'sh0_8000_0000);

   typedef struct packed {
      q_type [2:0] v;
      q_type [2:0] n;
      logic [30:0] eta;
   } vec_type;

   typedef struct packed {
      vec_type vec;
      q_type   edq;
      logic    tir;
   } side_type;

   typedef struct packed {
      q_type x;
      q_type y;
      q_type z;
      logic  tir;
   } res_type;

   // clamp to the signed 32-bit range
   function automatic q_type sat_wide(input wide_type w);
      if (w > W_MAX) return q_type'(W_MAX[QW-1:0]);
      if (w < W_MIN) return q_type'(W_MIN[QW-1:0]);
      return q_type'(w[QW-1:0]);
   endfunction

   // floor shift of an exact product, widened
   function automatic wide_type fshift(input prod_type p);
      wide_type w;
      w = {{2{p[63]}}, p};
      return w >>> FRAC_BITS;
   endfunction

   // Q-format product scale: floor shift then saturate
   function automatic q_type qscale(input prod_type p);
      return sat_wide(fshift(p));
   endfunction

   function automatic wide_type wext(input q_type a);
      return {{34{a[QW-1]}}, a};
   endfunction

   function automatic prod_type smul(input q_type a, input q_type b);
      return prod_type'({{32{a[QW-1]}}, a}) * prod_type'({{32{b[QW-1]}}, b});
   endfunction

   function automatic q_type eta_q(input logic [30:0] e);
      return q_type'({1'b0, e});
   endfunction

endpackage
`default_nettype wire

FILE: rtl/vector_refraction.sv
// Pipeline: an accepted req beat passes 6 front stages, 24 square-root stages at
//   one root bit each, 3 back stages and the output register to its rsp beat.
// Throughput: one beat per cycle while req_stall is low.
// Reset: synchronous active-high reset clears all valid bits and the skid entry;
//   data registers are not reset.
`default_nettype none
module vector_refraction (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  signed [31:0]  req_inc_x,
   input  wire  signed [31:0]  req_inc_y,
   input  wire  signed [31:0]  req_inc_z,
   input  wire  signed [31:0]  req_nrm_x,
   input  wire  signed [31:0]  req_nrm_y,
   input  wire  signed [31:0]  req_nrm_z,
   input  wire         [30:0]  req_index_ratio,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic signed [31:0]  rsp_out_x,
   output logic signed [31:0]  rsp_out_y,
   output logic signed [31:0]  rsp_out_z,
   output logic                rsp_total_internal
);
   import vr_pkg::*;

   logic          en, skid_full;
   vec_type       in_vec;
   logic          f_valid, s_valid, b_valid;
   q_type         f_k;
   side_type      f_side, s_side;
   logic [RW-1:0] s_root;
   res_type       b_res, o_res;

   // whole pipeline advances while the skid entry is free
   assign en        = !skid_full;
   assign req_stall = !en;

   assign in_vec.v   = {req_inc_z, req_inc_y, req_inc_x};
   assign in_vec.n   = {req_nrm_z, req_nrm_y, req_nrm_x};
   assign in_vec.eta = req_index_ratio;

   vr_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_vec(in_vec),
      .out_valid(f_valid), .out_k(f_k), .out_side(f_side)
   );

   vr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid), .in_k(f_k), .in_side(f_side),
      .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
   );

   vr_back u_back (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_root(s_root), .in_side(s_side),
      .out_valid(b_valid), .out_res(b_res)
   );

   vr_skid u_skid (
      .clock(clock), .reset(reset),
      .in_valid(b_valid), .in_res(b_res), .in_stall(skid_full),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_res(o_res)
   );

   assign rsp_out_x          = o_res.x;
   assign rsp_out_y          = o_res.y;
   assign rsp_out_z          = o_res.z;
   assign rsp_total_internal = o_res.tir;

endmodule
`default_nettype wire

FILE: rtl/vr_front.sv
// ----------------------------------------------------------------------------
// vr_front
// Six-stage front end: dot product, eta^2, 1-d^2 and k with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module vr_front (
   input  wire             clock,
   input  wire             reset,
   input  wire             en,
   input  wire             in_valid,
   input  vr_pkg::vec_type in_vec,
   output logic            out_valid,
   output vr_pkg::q_type   out_k,
   output vr_pkg::side_type out_side
);
   import vr_pkg::*;

   logic [6:1]    vld_ff;
   vec_type       vec_ff [6:1];
   prod_type      p_ff [3];
   prod_type      pe_ff;
   q_type         d_ff, e2_ff, e2b_ff, e2c_ff, t_ff, edq_ff, edqb_ff, edqc_ff, k_ff;
   prod_type      dd_ff, ed_ff, et_ff;
   wide_type      dsum;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:1], in_valid};
      end
   end

   assign dsum = fshift(p_ff[0]) + fshift(p_ff[1]) + fshift(p_ff[2]);

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: v*n products, eta*eta
         vec_ff[1] <= in_vec;
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= smul(in_vec.v[i], in_vec.n[i]);
         end
         pe_ff     <= smul(eta_q(in_vec.eta), eta_q(in_vec.eta));
         // stage 2: d, e2
         vec_ff[2] <= vec_ff[1];
         d_ff      <= sat_wide(dsum);
         e2_ff     <= qscale(pe_ff);
         // stage 3: d*d, eta*d
         vec_ff[3] <= vec_ff[2];
         dd_ff     <= smul(d_ff, d_ff);
         ed_ff     <= smul(eta_q(vec_ff[2].eta), d_ff);
         e2b_ff    <= e2_ff;
         // stage 4: t = 1 - d^2
         vec_ff[4] <= vec_ff[3];
         t_ff      <= sat_wide(wext(ONE_Q) - wext(qscale(dd_ff)));
         edq_ff    <= qscale(ed_ff);
         e2c_ff    <= e2b_ff;
         // stage 5: e2*t
         vec_ff[5] <= vec_ff[4];
         et_ff     <= smul(e2c_ff, t_ff);
         edqb_ff   <= edq_ff;
         // stage 6: k
         vec_ff[6] <= vec_ff[5];
         k_ff      <= sat_wide(wext(ONE_Q) - wext(qscale(et_ff)));
         edqc_ff   <= edqb_ff;
      end
   end

   assign out_valid     = vld_ff[6];
   assign out_k         = k_ff;
   assign out_side.vec  = vec_ff[6];
   assign out_side.edq  = edqc_ff;
   assign out_side.tir  = k_ff[QW-1];

endmodule
`default_nettype wire

FILE: rtl/vr_sqrt.sv
// ----------------------------------------------------------------------------
// vr_sqrt
// Pipelined integer square root of k << FRAC_BITS, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vr_sqrt (
   input  wire              clock,
   input  wire              reset,
   input  wire              en,
   input  wire              in_valid,
   input  vr_pkg::q_type    in_k,
   input  vr_pkg::side_type in_side,
   output logic             out_valid,
   output logic [vr_pkg::RW-1:0] out_root,
   output vr_pkg::side_type out_side
);
   import vr_pkg::*;

   logic [RW-1:0]   vld_ff;
   logic [XP-1:0]   x_ff    [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   side_type        side_ff [RW];
   logic [XP-1:0]   x_in    [RW];
   logic [RW+1:0]   rem_in  [RW];
   logic [RW-1:0]   root_in [RW];
   logic [XP-1:0]   x_src   [RW];
   logic [RW+1:0]   rem_src [RW];
   logic [RW-1:0]   root_src[RW];
   logic [RW+1:0]   cur     [RW];
   logic [RW+1:0]   trial   [RW];
   logic [XP-1:0]   rad;

   // negative k gives no root; feed zero
   assign rad = in_k[QW-1] ? '0 : XP'({in_k[QW-2:0], {FRAC_BITS{1'b0}}});

   // one restoring step per stage
   always_comb begin
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            x_src[j]    = rad;
            rem_src[j]  = '0;
            root_src[j] = '0;
         end else begin
            x_src[j]    = x_ff[j-1];
            rem_src[j]  = rem_ff[j-1];
            root_src[j] = root_ff[j-1];
         end
         cur[j]   = {rem_src[j][RW-1:0], x_src[j][XP-1 -: 2]};
         trial[j] = {root_src[j], 2'b01};
         x_in[j]  = x_src[j] << 2;
         if (cur[j] >= trial[j]) begin
            rem_in[j]  = cur[j] - trial[j];
            root_in[j] = {root_src[j][RW-2:0], 1'b1};
         end else begin
            rem_in[j]  = cur[j];
            root_in[j] = {root_src[j][RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < RW; j++) begin
            x_ff[j]    <= x_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            side_ff[j] <= (j == 0) ? in_side : side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule
`default_nettype wire

FILE: rtl/vr_back.sv
// ----------------------------------------------------------------------------
// vr_back
// Three-stage back end: m = eta*d + sqrt(k), products, final difference.
// ----------------------------------------------------------------------------
`default_nettype none
module vr_back (
   input  wire              clock,
   input  wire              reset,
   input  wire              en,
   input  wire              in_valid,
   input  wire [vr_pkg::RW-1:0] in_root,
   input  vr_pkg::side_type in_side,
   output logic             out_valid,
   output vr_pkg::res_type  out_res
);
   import vr_pkg::*;

   logic [2:0]  vld_ff;
   side_type    s1_ff, s2_ff;
   q_type       m_ff;
   prod_type    pv_ff [3];
   prod_type    pm_ff [3];
   q_type       r_in  [3];
   res_type     res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // final difference, zero on total internal reflection
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_in[i] = s2_ff.tir ? '0 :
                   sat_wide(wext(qscale(pv_ff[i])) - wext(qscale(pm_ff[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: m
         s1_ff <= in_side;
         m_ff  <= sat_wide(wext(in_side.edq) + wide_type'({1'b0, in_root}));
         // stage 2: eta*v and m*n
         s2_ff <= s1_ff;
         for (int i = 0; i < 3; i++) begin
            pv_ff[i] <= smul(eta_q(s1_ff.vec.eta), s1_ff.vec.v[i]);
            pm_ff[i] <= smul(m_ff, s1_ff.vec.n[i]);
         end
         // stage 3: result
         res_ff.x   <= r_in[0];
         res_ff.y   <= r_in[1];
         res_ff.z   <= r_in[2];
         res_ff.tir <= s2_ff.tir;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_res   = res_ff;

endmodule
`default_nettype wire

FILE: rtl/vr_skid.sv
// ----------------------------------------------------------------------------
// vr_skid
// Output register with one skid entry; decouples the pipeline from rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none
module vr_skid (
   input  wire             clock,
   input  wire             reset,
   input  wire             in_valid,
   input  vr_pkg::res_type in_res,
   output logic            in_stall,
   output logic            out_valid,
   input  wire             out_stall,
   output vr_pkg::res_type out_res
);
   import vr_pkg::*;

   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   res_type out_ff, out_in;
   res_type skid_ff, skid_in;
   logic    take;

   assign take = in_valid && !skid_vld_ff;

   // next-state for output and skid beats
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || !out_stall) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = take;
            out_in      = in_res;
         end
      end else if (take) begin
         skid_vld_in = 1'b1;
         skid_in     = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_vld_ff;
   assign out_valid = out_vld_ff;
   assign out_res   = out_ff;

endmodule
`default_nettype wire

FILE: rtl/vr_checker.sv
// ----------------------------------------------------------------------------
// vr_checker
// Port-level checks on the result channel, bound to vector_refraction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector_refraction_macros.svh"
module vr_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire signed [31:0] req_inc_x,
   input wire signed [31:0] req_inc_y,
   input wire signed [31:0] req_inc_z,
   input wire signed [31:0] req_nrm_x,
   input wire signed [31:0] req_nrm_y,
   input wire signed [31:0] req_nrm_z,
   input wire        [30:0] req_index_ratio,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire signed [31:0] rsp_out_x,
   input wire signed [31:0] rsp_out_y,
   input wire signed [31:0] rsp_out_z,
   input wire               rsp_total_internal
);

   // a stalled rsp beat stays
   `VR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped")
   // and its x, y and z payload does not move
   `VR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z), "rsp payload changed")
   // total internal reflection gives the zero vector
   `VR_ASSERT_NOW(a_tir_zero, clock, reset, rsp_valid && rsp_total_internal, rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0 && rsp_out_z == 32'sd0, "nonzero vector on total internal reflection")
   // nothing comes out right after reset
   `VR_ASSERT_NOW(a_rst_idle, clock, reset, $past(reset), !rsp_valid, "rsp beat right after reset")

endmodule

bind vector_refraction vr_checker u_vr_checker (.*);
`default_nettype wire
